FILE: rtl/gcspm_pkg.sv
// ----------------------------------------------------------------------------
// gcspm_pkg
// shared types, constants and decode functions for the game-pad poll master
// ----------------------------------------------------------------------------
package gcspm_pkg;

    // field widths
    localparam int unsigned GapW     = 16;
    localparam int unsigned DelayW   = 8;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned ButtonW  = 10;
    localparam int unsigned DpadW    = 4;
    localparam int unsigned CfgAddrW = 2;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 32;
    localparam int unsigned NumBytes = 5;

    // register reset values
    localparam logic [GapW-1:0]   GapReset    = 16'd50;
    localparam logic [DelayW-1:0] LowReset    = 8'd2;
    localparam logic [DelayW-1:0] SampleReset = 8'd1;
    localparam logic [DelayW-1:0] PostReset   = 8'd1;

    // configuration register indexes
    typedef enum logic [CfgAddrW-1:0] {
        CFG_BYTE_GAP     = 2'd0,
        CFG_CLOCK_LOW    = 2'd1,
        CFG_SAMPLE_DELAY = 2'd2,
        CFG_POST_SAMPLE  = 2'd3
    } t_cfg_index;

    // link phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_GAP    = 5'b00010,
        PH_LOW    = 5'b00100,
        PH_SAMPLE = 5'b01000,
        PH_POST   = 5'b10000
    } t_phase;

    // command byte sent in each exchange
    function automatic logic [ByteW-1:0] tx_byte(input logic [2:0] idx);
        logic [ByteW-1:0] b;
        case (idx)
            3'd0:    b = 8'h01;
            3'd1:    b = 8'h42;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // active-low answer bytes to active-high buttons
    function automatic logic [ButtonW-1:0] decode_buttons(input logic [ByteW-1:0] a1,
                                                          input logic [ByteW-1:0] a2);
        return {~a1[4], ~a1[7], ~a2[6], ~a2[7], ~a2[4], ~a2[5],
                ~a2[0], ~a2[3], ~a2[1], ~a2[2]};
    endfunction

    function automatic logic [DpadW-1:0] decode_dpad(input logic [ByteW-1:0] a1);
        return {~a1[2], ~a1[0], ~a1[1], ~a1[3]};
    endfunction

endpackage

FILE: rtl/game_controller_serial_poll_master_core.sv
// ----------------------------------------------------------------------------
// game_controller_serial_poll_master_core
// tick-driven poll master for a game-pad serial link
// ----------------------------------------------------------------------------
// usage:
//   every request on the slave stream is one timing tick of the link.
//   s_axis_tdata[0] = start_poll, s_axis_tdata[1] = data_line (pad data level).
//   each request yields exactly one result on the master stream giving the
//   line levels and status after that tick: attention, clock, command, busy,
//   poll_done, pad id, buttons and direction pad.
//   the tick is evaluated combinationally from the link state and the result
//   lands in the output register on the accept edge.
//   throughput is one request per clock; the output register is refilled on
//   the same edge it is drained, so ready stays high while the receiver takes
//   results.
//   if the receiver stalls, the result holds in the output register and
//   s_axis_tready drops until it is taken; no tick advances meanwhile.
//   reset puts the link idle (attention and clock high), clears the decoded
//   outputs and restores the timing registers (gap 50, low 2, sample 1, post 1).
//   timing registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata
//   and apply from the next tick on.
// ----------------------------------------------------------------------------
module game_controller_serial_poll_master_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [gcspm_pkg::CfgAddrW-1:0]        i_cfg_addr,
    input  logic [gcspm_pkg::CfgDataW-1:0]        i_cfg_wdata,
    // tick requests
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [0] start_poll, [1] data_line, [7:2] zero
    input  logic [gcspm_pkg::InDataW-1:0]         s_axis_tdata,
    // results
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] attention_line, [1] clock_line, [2] command_line, [3] busy_res,
    // [4] poll_done, [12:5] pad_id, [22:13] buttons, [26:23] dpad, [31:27] zero
    output logic [gcspm_pkg::OutDataW-1:0]        m_axis_tdata
);
    import gcspm_pkg::*;

    // timing registers
    logic [GapW-1:0]   r_gap_ticks;
    logic [DelayW-1:0] r_low_ticks;
    logic [DelayW-1:0] r_sample_ticks;
    logic [DelayW-1:0] r_post_ticks;

    // link state
    t_phase            r_phase,   n_phase;
    logic [2:0]        r_byte_idx, n_byte_idx;
    logic [2:0]        r_bit_idx,  n_bit_idx;
    logic [GapW-1:0]   r_tick,     n_tick;
    logic [ByteW-1:0]  r_tx_shift, n_tx_shift;
    logic [ByteW-1:0]  r_rx_shift, n_rx_shift;
    logic [ByteW-1:0]  r_first_ans, n_first_ans;
    logic [ButtonW-1:0] r_buttons, n_buttons;
    logic [DpadW-1:0]  r_dpad,     n_dpad;
    logic [ByteW-1:0]  r_id,       n_id;

    // output register
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic [OutDataW-1:0] n_out_data;

    logic              s_accept;
    logic              start;
    logic              data_bit;
    logic              done;
    logic [GapW:0]     tick_inc;
    logic [GapW:0]     limit;
    logic              over;
    logic              idle;
    logic              bitstep;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign start         = s_axis_tdata[0];
    assign data_bit      = s_axis_tdata[1];
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // wait-step limit for the current phase; zero behaves as one
    always_comb begin
        unique case (r_phase)
            PH_GAP:    limit = {1'b0, r_gap_ticks};
            PH_LOW:    limit = {{(GapW+1-DelayW){1'b0}}, r_low_ticks};
            PH_SAMPLE: limit = {{(GapW+1-DelayW){1'b0}}, r_sample_ticks};
            PH_POST:   limit = {{(GapW+1-DelayW){1'b0}}, r_post_ticks};
            default:   limit = '0;
        endcase
    end

    assign tick_inc = {1'b0, r_tick} + {{GapW{1'b0}}, 1'b1};
    assign over     = (tick_inc >= limit);

    // one link tick
    always_comb begin
        n_phase     = r_phase;
        n_byte_idx  = r_byte_idx;
        n_bit_idx   = r_bit_idx;
        n_tick      = over ? '0 : tick_inc[GapW-1:0];
        n_tx_shift  = r_tx_shift;
        n_rx_shift  = r_rx_shift;
        n_first_ans = r_first_ans;
        n_buttons   = r_buttons;
        n_dpad      = r_dpad;
        n_id        = r_id;
        done        = 1'b0;
        unique case (r_phase)
            PH_GAP: begin
                if (over) n_phase = PH_LOW;
            end
            PH_LOW: begin
                if (over) n_phase = PH_SAMPLE;
            end
            PH_SAMPLE: begin
                if (over) begin
                    n_rx_shift = {data_bit, r_rx_shift[ByteW-1:1]};
                    n_phase    = PH_POST;
                end
            end
            PH_POST: begin
                if (over) begin
                    if (r_bit_idx != 3'd7) begin
                        n_bit_idx  = r_bit_idx + 3'd1;
                        n_tx_shift = {1'b0, r_tx_shift[ByteW-1:1]};
                        n_phase    = PH_LOW;
                    end else begin
                        // end of byte: capture pad id and first answer byte
                        if (r_byte_idx == 3'd1) n_id = r_rx_shift;
                        if (r_byte_idx == 3'd3) n_first_ans = r_rx_shift;
                        if (r_byte_idx == 3'(NumBytes - 1)) begin
                            n_buttons  = decode_buttons(r_first_ans, r_rx_shift);
                            n_dpad     = decode_dpad(r_first_ans);
                            n_phase    = PH_IDLE;
                            n_byte_idx = '0;
                            done       = 1'b1;
                        end else begin
                            n_byte_idx = r_byte_idx + 3'd1;
                            n_tx_shift = tx_byte(r_byte_idx + 3'd1);
                            n_phase    = PH_GAP;
                        end
                        n_bit_idx  = '0;
                        n_rx_shift = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = r_tick;
                if (start) begin
                    n_phase    = PH_GAP;
                    n_byte_idx = '0;
                    n_bit_idx  = '0;
                    n_tick     = '0;
                    n_tx_shift = tx_byte(3'd0);
                    n_rx_shift = '0;
                end
            end
        endcase
    end

    // result word from the state after the tick
    assign idle    = (n_phase == PH_IDLE);
    assign bitstep = (n_phase == PH_LOW) || (n_phase == PH_SAMPLE) || (n_phase == PH_POST);

    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = idle;
        n_out_data[1]     = (n_phase != PH_LOW);
        n_out_data[2]     = bitstep && n_tx_shift[0];
        n_out_data[3]     = !idle;
        n_out_data[4]     = done;
        n_out_data[12:5]  = n_id;
        n_out_data[22:13] = n_buttons;
        n_out_data[26:23] = n_dpad;
    end

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks    <= GapReset;
            r_low_ticks    <= LowReset;
            r_sample_ticks <= SampleReset;
            r_post_ticks   <= PostReset;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_BYTE_GAP:     r_gap_ticks    <= i_cfg_wdata;
                CFG_CLOCK_LOW:    r_low_ticks    <= i_cfg_wdata[DelayW-1:0];
                CFG_SAMPLE_DELAY: r_sample_ticks <= i_cfg_wdata[DelayW-1:0];
                CFG_POST_SAMPLE:  r_post_ticks   <= i_cfg_wdata[DelayW-1:0];
                default: ;
            endcase
        end
    end

    // link state advances one tick per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_byte_idx  <= '0;
            r_bit_idx   <= '0;
            r_tick      <= '0;
            r_tx_shift  <= '0;
            r_rx_shift  <= '0;
            r_first_ans <= '1;
            r_buttons   <= '0;
            r_dpad      <= '0;
            r_id        <= '0;
        end else if (s_accept) begin
            r_phase     <= n_phase;
            r_byte_idx  <= n_byte_idx;
            r_bit_idx   <= n_bit_idx;
            r_tick      <= n_tick;
            r_tx_shift  <= n_tx_shift;
            r_rx_shift  <= n_rx_shift;
            r_first_ans <= n_first_ans;
            r_buttons   <= n_buttons;
            r_dpad      <= n_dpad;
            r_id        <= n_id;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

FILE: rtl/gcspm_checker.sv
// ----------------------------------------------------------------------------
// gcspm_checker
// port-level checks for the game-pad poll master
// ----------------------------------------------------------------------------
module gcspm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [gcspm_pkg::OutDataW-1:0] m_axis_tdata
);
    import gcspm_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // attention low exactly while busy
    a_att_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] != m_axis_tdata[3]))
        else $error("attention and busy disagree");

    // done tick leaves the link idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0] && m_axis_tdata[1])
        else $error("done while link not idle");

    // clock only goes low during a poll
    a_clk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[3])
        else $error("clock low while idle");

    // command line quiet while idle
    a_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[2])
        else $error("command driven while idle");

endmodule

bind game_controller_serial_poll_master_core gcspm_checker u_gcspm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/game_controller_serial_poll_master_core_test.sv
// ----------------------------------------------------------------------------
// game_controller_serial_poll_master_core_test
// self-checking bench for the game-pad serial poll master
// ----------------------------------------------------------------------------
// every request is one link tick; a model of the link steps along with each
// accepted request and queues the line levels and status expected for that tick
// a checker compares every result field by field
// the pad side is emulated from the model's view of the link: answer bits land
// on the sampling ticks, opposite or random levels sit on all other ticks
// directed tests cover reset values, the default timing, answer patterns, a
// start held high, a pause in mid poll and the timing extremes
// a short random part follows with idle bursts on both streams, then a tail
// with both streams running flat out
// ----------------------------------------------------------------------------
module game_controller_serial_poll_master_core_test;
    import gcspm_pkg::*;

    localparam int unsigned WatchdogLimit = 1000;
    localparam int unsigned RandomTicks   = 150;
    localparam int unsigned MaxPrinted    = 40;

    // one result as packed on m_axis_tdata, lowest field last
    typedef struct packed {
        logic [4:0]         spare;
        logic [DpadW-1:0]   dpad;
        logic [ButtonW-1:0] buttons;
        logic [ByteW-1:0]   pad_id;
        logic               done;
        logic               busy;
        logic               cmd;
        logic               sclk;
        logic               attn;
    } t_tick_result;

    // command bytes of one poll
    localparam logic [ByteW-1:0] POLL_CMD [0:NumBytes-1] = '{8'h01, 8'h42, 8'h00, 8'h00, 8'h00};

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [CfgAddrW-1:0] i_cfg_addr    = '0;
    logic [CfgDataW-1:0] i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [0] start_poll, [1] data_line, [7:2] zero
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b1;
    // [0] attention, [1] clock, [2] command, [3] busy, [4] poll_done,
    // [12:5] pad_id, [22:13] buttons, [26:23] dpad, [31:27] zero
    logic [OutDataW-1:0] m_axis_tdata;

    game_controller_serial_poll_master_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // link model: timing registers and link state
    // ------------------------------------------------------------------
    logic [GapW-1:0]   byte_gap;
    logic [DelayW-1:0] clk_low;
    logic [DelayW-1:0] sample_wait;
    logic [DelayW-1:0] post_wait;

    t_phase            link_ph;
    logic [2:0]        byte_idx;
    logic [2:0]        bit_idx;
    logic [GapW-1:0]   tick_cnt;
    logic [ByteW-1:0]  tx_shift;
    logic [ByteW-1:0]  rx_shift;
    logic [ByteW-1:0]  first_ans;
    logic [ButtonW-1:0] held_buttons;
    logic [DpadW-1:0]  held_dpad;
    logic [ByteW-1:0]  held_id;

    t_tick_result      link_expected_q[$];

    // bench controls and counters
    bit                tx_idle_on  = 1'b1;
    bit                rx_stall_on = 1'b1;
    bit                noise_on    = 1'b0;
    logic [ByteW-1:0]  pad_answer [0:7];
    int unsigned       ticks_sent   = 0;
    int unsigned       results_seen = 0;
    int unsigned       polls_done   = 0;
    int unsigned       reg_writes   = 0;
    int unsigned       mismatch_cnt = 0;
    int unsigned       quiet_cycles = 0;

    task automatic reset_link_model();
        byte_gap     = GapReset;
        clk_low      = LowReset;
        sample_wait  = SampleReset;
        post_wait    = PostReset;
        link_ph      = PH_IDLE;
        byte_idx     = '0;
        bit_idx      = '0;
        tick_cnt     = '0;
        tx_shift     = '0;
        rx_shift     = '0;
        first_ans    = 8'hFF;
        held_buttons = '0;
        held_dpad    = '0;
        held_id      = '0;
        for (int i = 0; i < 8; i++) pad_answer[i] = 8'hFF;
    endtask

    // a wait of 0 ticks still lasts one tick
    function automatic logic wait_elapsed(input logic [GapW-1:0] span);
        logic [GapW:0] nxt;
        nxt = {1'b0, tick_cnt} + 1'b1;
        if (nxt >= {1'b0, span}) begin
            tick_cnt = '0;
            return 1'b1;
        end
        tick_cnt = nxt[GapW-1:0];
        return 1'b0;
    endfunction

    // one link tick; queues the levels and status seen after it
    task automatic advance_link(input logic start, input logic data);
        t_tick_result r;
        logic         done;
        logic [7:0]   n1;
        logic [7:0]   n2;
        done = 1'b0;
        case (link_ph)
            PH_GAP: begin
                if (wait_elapsed(byte_gap)) link_ph = PH_LOW;
            end
            PH_LOW: begin
                if (wait_elapsed({8'd0, clk_low})) link_ph = PH_SAMPLE;
            end
            PH_SAMPLE: begin
                if (wait_elapsed({8'd0, sample_wait})) begin
                    rx_shift = {data, rx_shift[7:1]};
                    link_ph  = PH_POST;
                end
            end
            PH_POST: begin
                if (wait_elapsed({8'd0, post_wait})) begin
                    if (bit_idx != 3'd7) begin
                        bit_idx  = bit_idx + 1'b1;
                        tx_shift = tx_shift >> 1;
                        link_ph  = PH_LOW;
                    end else begin
                        if (byte_idx == 3'd1) held_id = rx_shift;
                        else if (byte_idx == 3'd3) first_ans = rx_shift;
                        if (byte_idx >= 3'(NumBytes - 1)) begin
                            // answers are active low
                            n1 = ~first_ans;
                            n2 = ~rx_shift;
                            held_buttons[0] = n2[2];
                            held_buttons[1] = n2[1];
                            held_buttons[2] = n2[3];
                            held_buttons[3] = n2[0];
                            held_buttons[4] = n2[5];
                            held_buttons[5] = n2[4];
                            held_buttons[6] = n2[7];
                            held_buttons[7] = n2[6];
                            held_buttons[8] = n1[7];
                            held_buttons[9] = n1[4];
                            held_dpad[0]    = n1[3];
                            held_dpad[1]    = n1[1];
                            held_dpad[2]    = n1[0];
                            held_dpad[3]    = n1[2];
                            link_ph  = PH_IDLE;
                            byte_idx = '0;
                            done     = 1'b1;
                        end else begin
                            byte_idx = byte_idx + 1'b1;
                            tx_shift = POLL_CMD[byte_idx];
                            link_ph  = PH_GAP;
                        end
                        bit_idx  = '0;
                        rx_shift = '0;
                    end
                end
            end
            default: begin
                // idle, and any stray code behaves as idle
                link_ph = PH_IDLE;
                if (start) begin
                    link_ph  = PH_GAP;
                    byte_idx = '0;
                    bit_idx  = '0;
                    tick_cnt = '0;
                    tx_shift = POLL_CMD[0];
                    rx_shift = '0;
                end
            end
        endcase
        r         = '0;
        r.attn    = (link_ph == PH_IDLE);
        r.sclk    = (link_ph != PH_LOW);
        r.cmd     = (link_ph == PH_LOW || link_ph == PH_SAMPLE || link_ph == PH_POST) ?
                    tx_shift[0] : 1'b0;
        r.busy    = (link_ph != PH_IDLE);
        r.done    = done;
        r.pad_id  = held_id;
        r.buttons = held_buttons;
        r.dpad    = held_dpad;
        link_expected_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // send one tick request, with an optional idle burst in front
    task automatic send_tick(input logic start, input logic data);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, data, start};
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
        advance_link(start, data);
    endtask

    // pad emulation: the answer bit on sampling ticks, opposite or noise elsewhere
    task automatic pad_tick(input logic start);
        logic want;
        logic d;
        want = pad_answer[byte_idx][bit_idx];
        if (link_ph == PH_SAMPLE) d = want;
        else if (noise_on) d = 1'($urandom_range(0, 1));
        else d = ~want;
        send_tick(start, d);
    endtask

    // lower valid and hold off until every queued result has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (link_expected_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // register write, only with no request in flight
    task automatic set_reg(input t_cfg_index idx, input logic [CfgDataW-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BYTE_GAP:     byte_gap    = value;
            CFG_CLOCK_LOW:    clk_low     = value[DelayW-1:0];
            CFG_SAMPLE_DELAY: sample_wait = value[DelayW-1:0];
            CFG_POST_SAMPLE:  post_wait   = value[DelayW-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_timing(input logic [15:0] gap, input logic [15:0] low,
                              input logic [15:0] smp, input logic [15:0] post);
        set_reg(CFG_BYTE_GAP, gap);
        set_reg(CFG_CLOCK_LOW, low);
        set_reg(CFG_SAMPLE_DELAY, smp);
        set_reg(CFG_POST_SAMPLE, post);
    endtask

    task automatic run_until_idle(input logic hold);
        while (link_ph != PH_IDLE) pad_tick(hold);
    endtask

    // one full poll with the given answers; hold keeps start high throughout
    task automatic run_poll(input logic [7:0] id, input logic [7:0] a1,
                            input logic [7:0] a2, input logic hold);
        pad_answer[0] = 8'($urandom);
        pad_answer[1] = id;
        pad_answer[2] = 8'($urandom);
        pad_answer[3] = a1;
        pad_answer[4] = a2;
        pad_tick(1'b1);
        run_until_idle(hold);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_cnt < MaxPrinted)
            $display("mismatch at result %0d: %s expected 0x%0h got 0x%0h",
                     results_seen, what, want, got);
        mismatch_cnt++;
    endtask

    // receiver stalls in random bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_stall_on && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_tick_result got;
        t_tick_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (link_expected_q.size() == 0) begin
                report_mismatch("result with no request pending", '0, got);
            end else begin
                want = link_expected_q.pop_front();
                if (got.attn !== want.attn)
                    report_mismatch("attention", 32'(want.attn), 32'(got.attn));
                if (got.sclk !== want.sclk)
                    report_mismatch("clock", 32'(want.sclk), 32'(got.sclk));
                if (got.cmd !== want.cmd)
                    report_mismatch("command", 32'(want.cmd), 32'(got.cmd));
                if (got.busy !== want.busy)
                    report_mismatch("busy", 32'(want.busy), 32'(got.busy));
                if (got.done !== want.done)
                    report_mismatch("poll_done", 32'(want.done), 32'(got.done));
                if (got.pad_id !== want.pad_id)
                    report_mismatch("pad_id", 32'(want.pad_id), 32'(got.pad_id));
                if (got.buttons !== want.buttons)
                    report_mismatch("buttons", 32'(want.buttons), 32'(got.buttons));
                if (got.dpad !== want.dpad)
                    report_mismatch("dpad", 32'(want.dpad), 32'(got.dpad));
                if (got.spare !== want.spare)
                    report_mismatch("spare bits", 32'(want.spare), 32'(got.spare));
            end
            results_seen++;
            if (got.done === 1'b1) polls_done++;
        end
    end

    // watchdog on cycles with no handshake on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     quiet_cycles, link_expected_q.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // idle ticks straight after reset, then one poll at reset timing
    task automatic test_reset_and_default_poll();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        // all buttons pressed
        run_poll(8'h41, 8'h00, 8'h00, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    // fast timing with zero gap, sample and post waits, answer patterns that flip every decoded bit
    task automatic test_answer_patterns();
        set_timing(16'd0, 16'd1, 16'd0, 16'd0);
        run_poll(8'hFF, 8'hFF, 8'hFF, 1'b0);
        run_poll(8'h73, 8'h55, 8'hAA, 1'b0);
        // clock low of zero still lasts one tick
        set_reg(CFG_CLOCK_LOW, 16'd0);
        run_poll(8'h00, 8'hAA, 8'h55, 1'b0);
    endtask

    // start held high: ignored while busy and on the completing tick
    task automatic test_start_held();
        set_timing(16'd1, 16'd1, 16'd1, 16'd0);
        run_poll(8'h12, 8'hF0, 8'h0F, 1'b1);
        run_poll(8'h34, 8'h3C, 8'hC3, 1'b1);
    endtask

    // sender stops mid poll until all results are back, timing changes meanwhile
    task automatic test_pause_mid_poll();
        pad_answer[3] = 8'hE7;
        pad_answer[4] = 8'h18;
        pad_answer[1] = 8'h9C;
        pad_tick(1'b1);
        repeat (37) pad_tick(1'b0);
        drain_results();
        repeat (29) pad_tick(1'b0);
        set_reg(CFG_POST_SAMPLE, 16'd3);
        run_until_idle(1'b0);
    endtask

    // longest gap and longest bit steps, cut short by lowering the limits mid wait
    task automatic test_timing_extremes();
        set_timing(16'hFFFF, 16'd1, 16'd0, 16'd0);
        pad_answer[1] = 8'hC5;
        pad_answer[3] = 8'h3A;
        pad_answer[4] = 8'h6D;
        pad_tick(1'b1);
        repeat (20) pad_tick(1'b0);
        set_reg(CFG_BYTE_GAP, 16'd0);
        repeat (30) pad_tick(1'b0);
        set_timing(16'd2, 16'h00FF, 16'h00FF, 16'h00FF);
        repeat (260) pad_tick(1'b0);
        // upper write bits are dropped for the 8-bit registers
        set_timing(16'd0, 16'hAB01, 16'h5402, 16'hFF01);
        run_until_idle(1'b0);
    endtask

    task automatic randomize_timing();
        logic [15:0] gap;
        gap = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 60)) :
                                            16'($urandom_range(0, 3));
        set_timing(gap,
                   {8'($urandom), 8'($urandom_range(0, 2))},
                   {8'($urandom), 8'($urandom_range(0, 2))},
                   {8'($urandom), 8'($urandom_range(0, 2))});
    endtask

    // mostly complete polls with random answers, some noise ticks in between
    task automatic test_random_polls();
        int unsigned first_tick;
        int unsigned choice;
        logic        hold;
        first_tick = ticks_sent;
        while (ticks_sent - first_tick < RandomTicks) begin
            if ($urandom_range(0, 2) == 0) randomize_timing();
            choice   = $urandom_range(0, 9);
            noise_on = 1'($urandom_range(0, 1));
            if (choice == 0) begin
                repeat ($urandom_range(5, 30))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                hold = ($urandom_range(0, 3) == 0);
                run_poll(8'($urandom), 8'($urandom), 8'($urandom), hold);
                if (!hold) repeat ($urandom_range(0, 6)) pad_tick(1'b0);
            end
        end
        noise_on = 1'b0;
    endtask

    // last stretch with both streams running flat out
    task automatic test_no_idle_tail();
        drain_results();
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        set_timing(16'd1, 16'd1, 16'd0, 16'd1);
        run_poll(8'h41, 8'hFE, 8'h7F, 1'b1);
        repeat (5) pad_tick(1'b0);
    endtask

    initial begin
        reset_link_model();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_and_default_poll();
        test_answer_patterns();
        test_start_held();
        test_pause_mid_poll();
        test_timing_extremes();
        test_random_polls();
        test_no_idle_tail();

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("run covered %0d ticks, %0d completed polls and %0d register writes",
                 ticks_sent, polls_done, reg_writes);
        $display("%0d results checked, %0d mismatches", results_seen, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/gcspm_pkg.sv
rtl/game_controller_serial_poll_master_core.sv
rtl/gcspm_checker.sv
verif/game_controller_serial_poll_master_core_test.sv
